// File: hw/rtl/pslf_pkg.sv
// shared types, widths and codes of the pulse start linear fit timer
package pslf_pkg;

  // result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_FLAT  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_BASELINE   = 2'd0;
  localparam logic [1:0] CFG_TRIGGER    = 2'd1;
  localparam logic [1:0] CFG_UNDERSHOOT = 2'd2;
  localparam logic [1:0] CFG_SPAN       = 2'd3;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int STATUS_W = 2;
  localparam int TIME_W   = 16;
  localparam int CFG_W    = 17;

  // datapath widths, sized for windows up to 7 and traces up to 1024 samples
  localparam int DELTA_W = 18;          // sample*16 - baseline
  localparam int X0_W    = 12;          // index of first fitted sample
  localparam int SY_W    = 21;          // sum of y
  localparam int SUY_W   = 24;          // sum of u*y
  localparam int ND_W    = 29;          // fit numerator and denominator
  localparam int XD_W    = X0_W + ND_W; // x0*D + N
  localparam int PW      = XD_W + 3;    // 5*(x0*D + N), divider dividend

  // header of one job handed from the front to the back
  typedef struct packed {
    logic                    fit;
    logic [STATUS_W-1:0]     status;
    logic signed [X0_W-1:0]  x0;
  } job_hdr_t;

  // back end status seen by the top level
  typedef struct packed {
    logic idle;
  } back_stat_t;

endpackage

// File: hw/rtl/pslf_front.sv
// front end: baseline subtraction, trigger run tracking and job classification
module pslf_front import pslf_pkg::*; #(
  parameter int FIT_WINDOW  = 5,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [15:0]                   baseline,
  input  logic [15:0]                   trigger_level,
  input  logic signed [CFG_W-1:0]       undershoot_level,
  input  logic [7:0]                    undershoot_span,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_W-1:0]           in_sample,
  input  logic                          in_last_sample,
  output logic                          job_valid,
  input  logic                          job_ready,
  output job_hdr_t                      job_hdr,
  output logic [FIT_WINDOW*DELTA_W-1:0] job_win
);

  localparam int HIST  = FIT_WINDOW + 1;
  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int RUN_W = $clog2(FIT_WINDOW + 1);
  localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [RUN_W-1:0]          run_r, run_nxt;
  logic signed [DELTA_W-1:0] deltas_r [HIST];
  logic signed [DELTA_W-1:0] deltas_nxt [HIST];
  logic                      decided_r, decided_nxt;

  logic signed [DELTA_W-1:0] diff;
  logic signed [DELTA_W-1:0] whole;
  logic                      under_hit;
  logic                      trig_hit;
  logic                      run_full;
  logic                      emit;
  logic                      accept;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    diff = $signed({2'b00, in_sample, 4'b0000}) - $signed({2'b00, baseline});
    // whole counts, truncated toward zero
    if (diff[DELTA_W-1] && (diff[3:0] != 4'd0)) begin
      whole = {diff[DELTA_W-1:4] + 14'd1, 4'b0000};
    end else begin
      whole = {diff[DELTA_W-1:4], 4'b0000};
    end
    under_hit = (CMP_W'(idx_r) <= CMP_W'(undershoot_span)) &&
                (whole <= $signed({undershoot_level[CFG_W-1], undershoot_level}));
    trig_hit  = whole >= $signed({2'b00, trigger_level});
    run_full  = run_r >= RUN_W'(FIT_WINDOW);
  end

  always_comb begin
    idx_nxt     = idx_r;
    run_nxt     = run_r;
    deltas_nxt  = deltas_r;
    decided_nxt = decided_r;
    emit        = 1'b0;
    job_hdr.fit    = 1'b0;
    job_hdr.status = ST_NONE;
    job_hdr.x0     = X0_W'(idx_r) - X0_W'(FIT_WINDOW + 1);

    if (accept) begin
      if (!decided_r) begin
        if (under_hit) begin
          job_hdr.status = ST_UNDER;
          emit           = 1'b1;
        end else if (run_full) begin
          job_hdr.fit    = 1'b1;
          job_hdr.status = ST_FOUND;
          emit           = 1'b1;
        end else if (trig_hit) begin
          run_nxt = run_r + 1'b1;
        end else begin
          run_nxt = '0;
        end

        if (emit) begin
          decided_nxt = 1'b1;
        end else begin
          for (int j = HIST - 1; j > 0; j--) begin
            deltas_nxt[j] = deltas_r[j-1];
          end
          deltas_nxt[0] = diff;
          if (idx_r < IDX_W'(MAX_SAMPLES)) begin
            idx_nxt = idx_r + 1'b1;
          end
          if (in_last_sample) begin
            job_hdr.fit    = 1'b0;
            job_hdr.status = ST_NONE;
            emit           = 1'b1;
          end
        end
      end

      // end of trace clears everything for the next one
      if (in_last_sample) begin
        idx_nxt     = '0;
        run_nxt     = '0;
        decided_nxt = 1'b0;
        for (int j = 0; j < HIST; j++) begin
          deltas_nxt[j] = '0;
        end
      end
    end
  end

  assign job_valid = emit;

  // window position u holds the sample fitted at x0 + u
  always_comb begin
    for (int u = 0; u < FIT_WINDOW; u++) begin
      job_win[u*DELTA_W +: DELTA_W] = deltas_r[FIT_WINDOW-u];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      run_r     <= '0;
      decided_r <= 1'b0;
      for (int j = 0; j < HIST; j++) begin
        deltas_r[j] <= '0;
      end
    end else begin
      idx_r     <= idx_nxt;
      run_r     <= run_nxt;
      decided_r <= decided_nxt;
      deltas_r  <= deltas_nxt;
    end
  end

endmodule

// File: hw/rtl/pslf_queue.sv
// two entry job queue between front and back
module pslf_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam logic [1:0] LEVEL_FULL = 2'd2;

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_r, rd_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign push_ready = cnt_r != LEVEL_FULL;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/pslf_back.sv
// back end: line fit sums, crossing time division, saturation and output register
module pslf_back import pslf_pkg::*; #(
  parameter int FIT_WINDOW = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  job_hdr_t                      job_hdr,
  input  logic [FIT_WINDOW*DELTA_W-1:0] job_win,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [STATUS_W-1:0]           out_status,
  output logic signed [TIME_W-1:0]      out_start_time_ns,
  output back_stat_t                    stat
);

  localparam int CNT_W  = $clog2(FIT_WINDOW);
  localparam int DCNT_W = $clog2(PW);
  localparam int SU     = FIT_WINDOW * (FIT_WINDOW - 1) / 2;
  localparam int SUU    = (FIT_WINDOW - 1) * FIT_WINDOW * (2 * FIT_WINDOW - 1) / 6;

  localparam logic signed [ND_W-1:0] SU_C  = ND_W'(SU);
  localparam logic signed [ND_W-1:0] SUU_C = ND_W'(SUU);
  localparam logic signed [ND_W-1:0] N_C   = ND_W'(FIT_WINDOW);
  localparam logic [PW-1:0]          POS_LIM  = PW'(32767);
  localparam logic [PW-1:0]          NEG_LIM  = PW'(32768);
  localparam logic signed [TIME_W-1:0] TIME_MAX = 16'sh7fff;
  localparam logic signed [TIME_W-1:0] TIME_MIN = 16'sh8000;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SUM  = 3'd1;
  localparam logic [2:0] B_ND   = 3'd2;
  localparam logic [2:0] B_XD   = 3'd3;
  localparam logic [2:0] B_PREP = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_SAT  = 3'd6;
  localparam logic [2:0] B_DONE = 3'd7;

  logic [2:0]                 state_r, state_nxt;
  logic signed [DELTA_W-1:0]  win_r [FIT_WINDOW];
  logic signed [DELTA_W-1:0]  win_nxt [FIT_WINDOW];
  logic signed [X0_W-1:0]     x0_r, x0_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SY_W-1:0]     sy_r, sy_nxt;
  logic signed [SUY_W-1:0]    suy_r, suy_nxt;
  logic signed [ND_W-1:0]     n_r, n_nxt;
  logic signed [ND_W-1:0]     d_r, d_nxt;
  logic signed [XD_W-1:0]     xd_r, xd_nxt;
  logic [PW-1:0]              quot_r, quot_nxt;
  logic [ND_W-1:0]            rem_r, rem_nxt;
  logic [ND_W-1:0]            dmag_r, dmag_nxt;
  logic                       neg_r, neg_nxt;
  logic [DCNT_W-1:0]          dcnt_r, dcnt_nxt;
  logic [STATUS_W-1:0]        res_status_r, res_status_nxt;
  logic signed [TIME_W-1:0]   res_time_r, res_time_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic signed [TIME_W-1:0]   out_time_r, out_time_nxt;

  logic signed [DELTA_W-1:0]  y_cur;
  logic signed [SUY_W-1:0]    y_ext, u_ext;
  logic signed [ND_W-1:0]     sy_x, suy_x;
  logic signed [XD_W-1:0]     x0_x, d_x, n_x;
  logic signed [PW-1:0]       xd_ext, p_c;
  logic [ND_W:0]              rem_sh;

  assign job_ready         = state_r == B_IDLE;
  assign stat.idle         = state_r == B_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_start_time_ns = out_time_r;

  always_comb begin
    y_cur  = win_r[cnt_r];
    y_ext  = SUY_W'(y_cur);
    u_ext  = $signed({{(SUY_W-CNT_W){1'b0}}, cnt_r});
    sy_x   = ND_W'(sy_r);
    suy_x  = ND_W'(suy_r);
    x0_x   = XD_W'(x0_r);
    d_x    = XD_W'(d_r);
    n_x    = XD_W'(n_r);
    xd_ext = PW'(xd_r);
    p_c    = (xd_ext <<< 2) + xd_ext;
    rem_sh = {rem_r, quot_r[PW-1]};
  end

  always_comb begin
    state_nxt      = state_r;
    win_nxt        = win_r;
    x0_nxt         = x0_r;
    cnt_nxt        = cnt_r;
    sy_nxt         = sy_r;
    suy_nxt        = suy_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    xd_nxt         = xd_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    dmag_nxt       = dmag_r;
    neg_nxt        = neg_r;
    dcnt_nxt       = dcnt_r;
    res_status_nxt = res_status_r;
    res_time_nxt   = res_time_r;
    out_status_nxt = out_status_r;
    out_time_nxt   = out_time_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          for (int u = 0; u < FIT_WINDOW; u++) begin
            win_nxt[u] = job_win[u*DELTA_W +: DELTA_W];
          end
          x0_nxt  = job_hdr.x0;
          cnt_nxt = '0;
          sy_nxt  = '0;
          suy_nxt = '0;
          if (job_hdr.fit) begin
            state_nxt = B_SUM;
          end else begin
            res_status_nxt = job_hdr.status;
            res_time_nxt   = '0;
            state_nxt      = B_DONE;
          end
        end
      end
      B_SUM: begin
        sy_nxt  = sy_r + SY_W'(y_cur);
        suy_nxt = suy_r + u_ext * y_ext;
        if (cnt_r == CNT_W'(FIT_WINDOW - 1)) begin
          state_nxt = B_ND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_ND: begin
        n_nxt     = SU_C * suy_x - SUU_C * sy_x;
        d_nxt     = N_C * suy_x - SU_C * sy_x;
        state_nxt = B_XD;
      end
      B_XD: begin
        if (d_r == '0) begin
          res_status_nxt = ST_FLAT;
          res_time_nxt   = '0;
          state_nxt      = B_DONE;
        end else begin
          xd_nxt    = x0_x * d_x + n_x;
          state_nxt = B_PREP;
        end
      end
      B_PREP: begin
        quot_nxt  = p_c[PW-1] ? PW'(-p_c) : p_c;
        dmag_nxt  = d_r[ND_W-1] ? ND_W'(-d_r) : d_r;
        neg_nxt   = p_c[PW-1] ^ d_r[ND_W-1];
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, dmag_r}) begin
          rem_nxt  = ND_W'(rem_sh - {1'b0, dmag_r});
          quot_nxt = {quot_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[ND_W-1:0];
          quot_nxt = {quot_r[PW-2:0], 1'b0};
        end
        if (dcnt_r == DCNT_W'(PW - 1)) begin
          state_nxt = B_SAT;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      B_SAT: begin
        res_status_nxt = ST_FOUND;
        if (neg_r) begin
          res_time_nxt = (quot_r > NEG_LIM) ? TIME_MIN : TIME_W'(-quot_r);
        end else begin
          res_time_nxt = (quot_r > POS_LIM) ? TIME_MAX : TIME_W'(quot_r);
        end
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_time_nxt   = res_time_r;
          state_nxt      = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    win_r        <= win_nxt;
    x0_r         <= x0_nxt;
    cnt_r        <= cnt_nxt;
    sy_r         <= sy_nxt;
    suy_r        <= suy_nxt;
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    xd_r         <= xd_nxt;
    quot_r       <= quot_nxt;
    rem_r        <= rem_nxt;
    dmag_r       <= dmag_nxt;
    neg_r        <= neg_nxt;
    dcnt_r       <= dcnt_nxt;
    res_status_r <= res_status_nxt;
    res_time_r   <= res_time_nxt;
    out_status_r <= out_status_nxt;
    out_time_r   <= out_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/pulse_start_linear_fit_timer_core.sv
// top level of the pulse start timer: config registers, front, job queue and fit back end
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready   in_sample, in_last_sample
//   out_     output     out_valid / out_ready out_status, out_start_time_ns
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// samples are taken one per cycle while the two entry job queue has room
// a fit job runs window sums and products in the back end, then, for a nonzero
// denominator, a 44 step restoring divider; other results skip to the output stage
// the back end output register lets the next job start while a result waits
// synchronous active low reset clears trace state, queue, back end and config registers
// a stalled output holds one result in the output register and one in the back end,
// two more jobs fill the queue, then in_ready drops
module pulse_start_linear_fit_timer_core import pslf_pkg::*; #(
  parameter int FIT_WINDOW  = 5,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      in_sample,
  input  logic                     in_last_sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [TIME_W-1:0] out_start_time_ns,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int JOB_W = $bits(job_hdr_t) + FIT_WINDOW * DELTA_W;

  // configuration registers
  logic [15:0]              baseline_r;
  logic [15:0]              trigger_level_r;
  logic signed [CFG_W-1:0]  undershoot_level_r;
  logic [7:0]               undershoot_span_r;

  // front to queue
  logic                          fq_valid, fq_ready;
  job_hdr_t                      fq_hdr;
  logic [FIT_WINDOW*DELTA_W-1:0] fq_win;

  // queue to back
  logic                          qb_valid, qb_ready;
  logic [JOB_W-1:0]              qb_data;
  job_hdr_t                      qb_hdr;
  logic [FIT_WINDOW*DELTA_W-1:0] qb_win;

  back_stat_t                    bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r         <= 16'd0;
      trigger_level_r    <= 16'd80;
      undershoot_level_r <= -17'sd160;
      undershoot_span_r  <= 8'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASELINE:   baseline_r         <= cfg_data[15:0];
        CFG_TRIGGER:    trigger_level_r    <= cfg_data[15:0];
        CFG_UNDERSHOOT: undershoot_level_r <= cfg_data;
        CFG_SPAN:       undershoot_span_r  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify each sample, hand decisions on as jobs
  pslf_front #(
    .FIT_WINDOW  (FIT_WINDOW),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .baseline         (baseline_r),
    .trigger_level    (trigger_level_r),
    .undershoot_level (undershoot_level_r),
    .undershoot_span  (undershoot_span_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .job_valid        (fq_valid),
    .job_ready        (fq_ready),
    .job_hdr          (fq_hdr),
    .job_win          (fq_win)
  );

  // short queue decouples sample intake from the long fit
  pslf_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  ({fq_hdr, fq_win}),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  assign qb_hdr = qb_data[JOB_W-1 -: $bits(job_hdr_t)];
  assign qb_win = qb_data[FIT_WINDOW*DELTA_W-1:0];

  // back: fit, divide, saturate and present the result
  pslf_back #(
    .FIT_WINDOW (FIT_WINDOW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (qb_valid),
    .job_ready         (qb_ready),
    .job_hdr           (qb_hdr),
    .job_win           (qb_win),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_start_time_ns (out_start_time_ns),
    .stat              (bstat)
  );

  // only a found result carries a time
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FOUND) |-> out_start_time_ns == '0)
    else $error("nonzero time on a result that is not found");

  // a new result only comes from a back end that was working on a job
  a_rise_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!bstat.idle))
    else $error("result appeared without a job in the back end");

  // after a transfer the output holds again only if the back end just finished a job
  a_reload_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || $past(!bstat.idle))
    else $error("output reloaded without a finished job");

endmodule
